### rtl/stpseq_pkg.sv
`timescale 1ns / 1ps
package stpseq_pkg;

  localparam int unsigned GROUP_W = 29;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned COIL_W  = 4;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_START   = 2'd1,
    REQ_LOAD_MS = 2'd2
  } stpseq_req_e_t;

  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  // Coil patterns, coil_1 in bit 0 through coil_4 in bit 3.
  localparam logic [3:0] WAVE_CW  [4] = '{4'd8, 4'd4, 4'd2, 4'd1};
  localparam logic [3:0] WAVE_CCW [4] = '{4'd1, 4'd2, 4'd4, 4'd8};
  localparam logic [3:0] FULL_CW  [4] = '{4'd9, 4'd12, 4'd6, 4'd3};
  localparam logic [3:0] FULL_CCW [4] = '{4'd3, 4'd6, 4'd12, 4'd9};
  localparam logic [3:0] HALF_CW  [8] = '{4'd9, 4'd8, 4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1};
  localparam logic [3:0] HALF_CCW [8] = '{4'd1, 4'd3, 4'd2, 4'd6, 4'd4, 4'd12, 4'd8, 4'd9};

  typedef struct packed {
    logic [1:0]         req_type;
    logic [STEP_W-1:0]  step_request;
    logic [SPEED_W-1:0] speed_ticks;
    logic               clockwise;
    logic [MS_W-1:0]    ms_value;
  } stpseq_req_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic [GROUP_W-1:0] steps_left;
    logic [MS_W-1:0]    ms_left;
    logic [PHASE_W-1:0] phase_now;
  } stpseq_res_t;

  function automatic logic [3:0] pattern_for(input logic [1:0] mode, input logic cw,
                                             input logic [PHASE_W-1:0] phase);
    logic [3:0] pat;
    case (mode)
      MODE_WAVE: pat = cw ? WAVE_CW[phase[1:0]] : WAVE_CCW[phase[1:0]];
      MODE_FULL: pat = cw ? FULL_CW[phase[1:0]] : FULL_CCW[phase[1:0]];
      default:   pat = cw ? HALF_CW[phase] : HALF_CCW[phase];
    endcase
    return pat;
  endfunction

endpackage

### rtl/stpseq_update.sv
`timescale 1ns / 1ps
module stpseq_update import stpseq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        step_en,
  input  stpseq_req_t req,
  output stpseq_res_t res
);

  logic [1:0]         mode_r;
  logic [GROUP_W-1:0] groups_r, groups_nxt;
  logic [SPEED_W-1:0] reload_r, reload_nxt;
  logic [SPEED_W-1:0] count_r, count_nxt;
  logic               cw_r, cw_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;
  logic [COIL_W-1:0]  coils_r, coils_nxt;

  always_comb begin
    logic [SPEED_W-1:0] cnt_dec;
    logic [PHASE_W:0]   phase_inc;
    logic               wrap;
    groups_nxt = groups_r;
    reload_nxt = reload_r;
    count_nxt  = count_r;
    cw_nxt     = cw_r;
    phase_nxt  = phase_r;
    ms_nxt     = ms_r;
    coils_nxt  = coils_r;
    cnt_dec    = count_r - 1'b1;
    // Half step walks all eight phases; wave and full step use the low two bits.
    if (mode_r[1]) begin
      phase_inc = {1'b0, phase_r} + 1'b1;
      wrap      = phase_inc[PHASE_W];
    end else begin
      phase_inc = {2'b00, phase_r[1:0]} + 1'b1;
      wrap      = phase_inc[2];
    end
    case (req.req_type)
      REQ_TICK: begin
        if (ms_r != '0) ms_nxt = ms_r - 1'b1;
        count_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          count_nxt = reload_r;
          if (groups_r != '0) begin
            coils_nxt = pattern_for(mode_r, cw_r, phase_r);
            if (wrap) begin
              phase_nxt  = '0;
              groups_nxt = groups_r - 1'b1;
            end else begin
              phase_nxt = phase_inc[PHASE_W-1:0];
            end
          end
          if (groups_nxt == '0) coils_nxt = '0;
        end
      end
      REQ_START: begin
        reload_nxt = req.speed_ticks;
        count_nxt  = req.speed_ticks;
        cw_nxt     = req.clockwise;
        groups_nxt = req.step_request[STEP_W-1:3];
      end
      REQ_LOAD_MS: ms_nxt = req.ms_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WAVE;
      groups_r <= '0;
      reload_r <= '0;
      count_r  <= '0;
      cw_r     <= 1'b0;
      phase_r  <= '0;
      ms_r     <= '0;
      coils_r  <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (step_en) begin
        groups_r <= groups_nxt;
        reload_r <= reload_nxt;
        count_r  <= count_nxt;
        cw_r     <= cw_nxt;
        phase_r  <= phase_nxt;
        ms_r     <= ms_nxt;
        coils_r  <= coils_nxt;
      end
    end
  end

  assign res.coils      = coils_nxt;
  assign res.steps_left = groups_nxt;
  assign res.ms_left    = ms_nxt;
  assign res.phase_now  = phase_nxt;

endmodule

### rtl/stepper_phase_sequencer_core.sv
`timescale 1ns / 1ps
// An accepted input beat passes the input register, then the state update into the result
// register.
// Throughput: one beat per cycle; a held result stalls the input only once the input
// register is also full.
// Reset (rst_n low, synchronous): coils off, all counters, phase and mode cleared.
module stepper_phase_sequencer_core import stpseq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,   // drive_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,      // step_request, speed_ticks, clockwise, ms_value, zero pad
  input  logic [1:0]  in_tuser,      // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata      // coil_1..coil_4, steps_left, ms_left, phase_now, zero pad
);

  logic        in_valid_r;
  stpseq_req_t in_req_r;
  logic        out_valid_r;
  stpseq_res_t out_res_r;
  stpseq_res_t res;
  logic        advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r.req_type     <= in_tuser;
      in_req_r.step_request <= in_tdata[31:0];
      in_req_r.speed_ticks  <= in_tdata[39:32];
      in_req_r.clockwise    <= in_tdata[40];
      in_req_r.ms_value     <= in_tdata[72:41];
    end
  end

  stpseq_update u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (advance),
    .req         (in_req_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.phase_now, out_res_r.ms_left,
                       out_res_r.steps_left, out_res_r.coils};

  // A held result beat keeps its data until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result beat changed");

  // The input stage only stalls behind a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");

  // Only a start move can raise the step group count.
  a_groups_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_req_r.req_type != REQ_START) |-> res.steps_left <= out_res_r.steps_left)
    else $error("step groups grew outside a start move");

endmodule

### tb/sv/stepper_phase_sequencer_core_tb.sv
`timescale 1ns / 1ps
module stepper_phase_sequencer_core_tb;
  import stpseq_pkg::*;

  localparam logic [1:0]  REQ_SPARE    = 2'd3;  // unused request code
  localparam logic [1:0]  MODE_SPARE   = 2'd3;  // unused mode, runs as half step
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic [GROUP_W-1:0] groups;
    logic [MS_W-1:0]    ms;
    logic [PHASE_W-1:0] phase;
  } drive_state_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // step_request, speed_ticks, clockwise, ms_value, zero pad
  logic [1:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // coil_1..coil_4, steps_left, ms_left, phase_now, zero pad

  // Predicted sequencer state.
  logic [1:0]         mdl_mode;
  logic [GROUP_W-1:0] mdl_groups;
  logic [SPEED_W-1:0] mdl_reload;
  logic [SPEED_W-1:0] mdl_count;
  logic               mdl_cw;
  logic [PHASE_W-1:0] mdl_phase;
  logic [MS_W-1:0]    mdl_ms;
  logic [COIL_W-1:0]  mdl_coils;

  drive_state_t drive_q[$];
  int unsigned  fail_count;
  bit           tx_idle_en;
  bit           rx_idle_en;
  bit           hold_off_req;

  const logic [1:0] mode_cycle[4] = '{MODE_WAVE, MODE_FULL, MODE_HALF, MODE_SPARE};

  stepper_phase_sequencer_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Half step interleaves the single-coil and two-coil patterns, so every
  // mode reduces to a shifted single coil or a rotated coil pair.
  function automatic logic [3:0] coil_pattern(input logic [1:0] mode, input logic cw,
                                              input logic [2:0] ph);
    logic       single;
    logic [1:0] idx;
    logic [7:0] pair;
    logic [3:0] pat;
    if (mode == MODE_WAVE || mode == MODE_FULL) begin
      single = (mode == MODE_WAVE);
      idx    = ph[1:0];
    end else begin
      single = cw ? ph[0] : !ph[0];
      idx    = ph[2:1];
    end
    if (single) begin
      pat = cw ? (4'b1000 >> idx) : (4'b0001 << idx);
    end else begin
      pair = cw ? ({4'b1001, 4'b1001} >> idx) : ({4'b0011, 4'b0011} << idx);
      pat  = cw ? pair[3:0] : pair[7:4];
    end
    return pat;
  endfunction

  task automatic advance_sequencer(input logic [1:0] kind, input logic [31:0] steps,
                                   input logic [7:0] speed, input logic cw,
                                   input logic [31:0] ms, output drive_state_t st);
    logic       four_phase;
    logic [3:0] nxt;
    case (kind)
      REQ_TICK: begin
        if (mdl_ms != '0) mdl_ms = mdl_ms - 1'b1;
        mdl_count = mdl_count - 1'b1;
        if (mdl_count == '0) begin
          mdl_count = mdl_reload;
          if (mdl_groups != '0) begin
            mdl_coils  = coil_pattern(mdl_mode, mdl_cw, mdl_phase);
            four_phase = (mdl_mode == MODE_WAVE || mdl_mode == MODE_FULL);
            nxt = (four_phase ? {2'b00, mdl_phase[1:0]} : {1'b0, mdl_phase}) + 4'd1;
            if (nxt == (four_phase ? 4'd4 : 4'd8)) begin
              nxt        = '0;
              mdl_groups = mdl_groups - 1'b1;
            end
            mdl_phase = nxt[2:0];
          end
          if (mdl_groups == '0) mdl_coils = '0;
        end
      end
      REQ_START: begin
        mdl_reload = speed;
        mdl_count  = speed;
        mdl_cw     = cw;
        mdl_groups = steps[31:3];
      end
      REQ_LOAD_MS: mdl_ms = ms;
      default: ;
    endcase
    st.coils  = mdl_coils;
    st.groups = mdl_groups;
    st.ms     = mdl_ms;
    st.phase  = mdl_phase;
  endtask

  task automatic push_request(input logic [1:0] kind, input logic [31:0] steps,
                              input logic [7:0] speed, input logic cw, input logic [31:0] ms);
    drive_state_t st;
    int unsigned  gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, ms, cw, speed, steps};
    do @(posedge clk); while (!in_tready);
    advance_sequencer(kind, steps, speed, cw, ms, st);
    drive_q.push_back(st);
  endtask

  // Fields that the request kind does not use carry random data.
  task automatic push_kind(input logic [1:0] kind);
    push_request(kind, $urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 $urandom);
  endtask

  task automatic push_start(input logic [31:0] steps, input logic [7:0] speed, input logic cw);
    push_request(REQ_START, steps, speed, cw, $urandom);
  endtask

  task automatic push_load(input logic [31:0] ms);
    push_request(REQ_LOAD_MS, $urandom, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), ms);
  endtask

  task automatic write_drive_mode(input logic [1:0] mode);
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_mode = mode;
  endtask

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch %0d at %0t ns: %s", fail_count, $time, what);
  endtask

  always @(posedge clk) begin : check_results
    drive_state_t want;
    drive_state_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.coils  = out_tdata[3:0];
      got.groups = out_tdata[32:4];
      got.ms     = out_tdata[64:33];
      got.phase  = out_tdata[67:65];
      if (drive_q.size() == 0) begin
        log_failure($sformatf("result beat with none expected, data %h", out_tdata));
      end else begin
        want = drive_q.pop_front();
        if (got.coils !== want.coils || got.groups !== want.groups ||
            got.ms !== want.ms || got.phase !== want.phase) begin
          log_failure({
            $sformatf("coils exp %h got %h, steps_left exp %0d got %0d, ",
                      want.coils, got.coils, want.groups, got.groups),
            $sformatf("ms_left exp %0d got %0d, phase exp %0d got %0d",
                      want.ms, got.ms, want.phase, got.phase)});
        end
      end
    end
  end

  // Result-side ready: random short stalls, plus one long hold-off on request.
  initial begin : result_sink
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready   <= 1'b0;
        hold_off_req = 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed_basics();
    push_kind(REQ_TICK);
    push_request(REQ_SPARE, '1, '1, 1'b1, '1);
    push_load(32'hFFFF_FFFF);
    push_kind(REQ_TICK);
    push_load(32'd1);
    push_kind(REQ_TICK);
    push_kind(REQ_TICK);
    push_start(32'hFFFF_FFFF, 8'd1, 1'b1);
    repeat (6) push_kind(REQ_TICK);
    // Fewer than eight steps leaves no group: the next divider expiry turns the coils off.
    push_start(32'd7, 8'd1, 1'b0);
    push_kind(REQ_TICK);
    push_start(32'd8, 8'd255, 1'b0);
    push_kind(REQ_TICK);
    push_start(32'd16, 8'd2, 1'b0);
    repeat (4) push_kind(REQ_TICK);
    push_start(32'd0, 8'd1, 1'b1);
    push_kind(REQ_TICK);
  endtask

  task automatic test_phase_carry();
    write_drive_mode(MODE_HALF);
    push_start(32'd16, 8'd1, 1'b1);
    repeat (5) push_kind(REQ_TICK);
    // Phase is now past the four-phase range; wave drive uses its low bits only.
    write_drive_mode(MODE_WAVE);
    push_kind(REQ_TICK);
    push_start(32'd16, 8'd1, 1'b0);
    write_drive_mode(MODE_HALF);
    repeat (4) push_kind(REQ_TICK);
    write_drive_mode(MODE_FULL);
    repeat (2) push_kind(REQ_TICK);
    write_drive_mode(MODE_SPARE);
    push_start(32'd8, 8'd1, 1'b1);
    repeat (9) push_kind(REQ_TICK);
  endtask

  task automatic test_slow_divider();
    write_drive_mode(MODE_FULL);
    push_start(32'd9, 8'd0, 1'($urandom_range(0, 1)));
    repeat (260) push_kind(REQ_TICK);
  endtask

  task automatic test_back_pressure();
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    push_start(32'd80, 8'd1, 1'($urandom_range(0, 1)));
    repeat (40) push_kind(REQ_TICK);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_moves(input int unsigned quota);
    int unsigned sent;
    int unsigned moves;
    logic [31:0] steps;
    logic [7:0]  speed;
    sent  = 0;
    moves = 0;
    while (sent < quota) begin
      if (moves % 5 == 0) write_drive_mode(mode_cycle[2'((moves / 5) % 4)]);
      else if ($urandom_range(0, 9) == 0) write_drive_mode(mode_cycle[2'($urandom_range(0, 3))]);
      if ($urandom_range(0, 2) == 0) begin
        push_load($urandom_range(0, 1) ? $urandom : $urandom_range(0, 30));
        sent++;
      end
      steps = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      speed = 8'(($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3));
      push_start(steps, speed, 1'($urandom_range(0, 1)));
      sent++;
      repeat ($urandom_range(8, 60)) begin
        case ($urandom_range(0, 19))
          0:       push_kind(REQ_SPARE);
          1:       push_load($urandom_range(0, 1) ? $urandom : $urandom_range(0, 30));
          2:       push_start($urandom, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          default: push_kind(REQ_TICK);
        endcase
        sent++;
      end
      moves++;
    end
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_moves(150);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_off_req = 1'b0;
    fail_count   = 0;
    mdl_mode     = MODE_WAVE;
    mdl_groups   = '0;
    mdl_reload   = '0;
    mdl_count    = '0;
    mdl_cw       = 1'b0;
    mdl_phase    = '0;
    mdl_ms       = '0;
    mdl_coils    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_phase_carry();
    test_slow_divider();
    test_back_pressure();
    test_random_moves(650);
    test_full_rate();

    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
